### rtl/hme_pkg.sv
// Shared widths, codes and state encodings for the hash multiset engine.
package hme_pkg;

    localparam int KEY_W       = 64;
    localparam int CMD_W       = 2;
    localparam int STATUS_W    = 2;
    localparam int MUL_W       = 32;
    localparam int BUCKETS_DEF = 1024;
    localparam int WAYS_DEF    = 4;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT = 2'd0,
        CMD_FIND   = 2'd1,
        CMD_DELETE = 2'd2,
        CMD_CLEAR  = 2'd3
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_ABSENT = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_REDUCE,
        S_UPDATE,
        S_SWEEP,
        S_REPLY
    } state_t;

    typedef enum logic [1:0] {
        M_IDLE,
        M_QUOT,
        M_BACK,
        M_FIX
    } mod_state_t;

    typedef struct packed {
        logic en;
        logic we;
    } ram_ctl_t;

endpackage

### rtl/hme_if.sv
// Request and response channel interfaces of the hash multiset engine.
interface hme_req_if;
    import hme_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [CMD_W-1:0]        cmd;
    logic signed [KEY_W-1:0] key;

    modport source (output valid, output cmd, output key, input ready);
    modport sink   (input valid, input cmd, input key, output ready);
endinterface

interface hme_rsp_if;
    import hme_pkg::*;

    logic                valid;
    logic                ready;
    logic                found;
    logic [STATUS_W-1:0] status;

    modport source (output valid, output found, output status, input ready);
    modport sink   (input valid, input found, input status, output ready);
endinterface

### rtl/hme_mod_unit.sv
// Iterative unit that takes a 64-bit key modulo the bucket count by reciprocal multiplication.
module hme_mod_unit #(
    parameter int BUCKETS = hme_pkg::BUCKETS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [hme_pkg::KEY_W-1:0]  key,
    output logic                       done,
    output logic [$clog2(BUCKETS)-1:0] bucket
);
    import hme_pkg::*;

    localparam int BKT_W   = $clog2(BUCKETS);
    localparam int DIGIT_W = MUL_W - BKT_W;
    localparam int CHUNKS  = (KEY_W + DIGIT_W - 1) / DIGIT_W;
    localparam int PAD_W   = CHUNKS * DIGIT_W;
    localparam int CHUNK_W = $clog2(CHUNKS);
    localparam logic [MUL_W-1:0] RECIP = MUL_W'((64'd1 << MUL_W) / 64'(BUCKETS));

    mod_state_t         state_reg, state_next;
    logic [BKT_W-1:0]   rem_reg, rem_next;
    logic [MUL_W-1:0]   x_reg, x_next;
    logic [MUL_W-1:0]   quot_reg, quot_next;
    logic [MUL_W-1:0]   diff_reg, diff_next;
    logic [CHUNK_W-1:0] chunk_reg, chunk_next;
    logic               done_reg, done_next;

    logic               last_chunk;
    logic [PAD_W-1:0]   key_pad;
    logic [DIGIT_W-1:0] digit;
    logic [MUL_W-1:0]   fold;
    logic [MUL_W-1:0]   mul_a;
    logic [MUL_W-1:0]   mul_b;
    logic [2*MUL_W-1:0] product;

    // Most significant chunk first. The partial remainder shifted up by one chunk
    // always fits in MUL_W bits, so the floor reciprocal gives a quotient that is
    // at most one short, and a single compare and subtract finishes the step.
    assign key_pad    = PAD_W'(key);
    assign digit      = key_pad[(CHUNKS - 1 - int'(chunk_reg)) * DIGIT_W +: DIGIT_W];
    assign fold       = {rem_reg, digit};
    assign last_chunk = (chunk_reg == CHUNK_W'(CHUNKS - 1));
    assign product    = mul_a * mul_b;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            M_IDLE:
            begin
                if (start)
                begin
                    state_next = M_QUOT;
                end
            end
            M_QUOT:
            begin
                state_next = M_BACK;
            end
            M_BACK:
            begin
                state_next = M_FIX;
            end
            M_FIX:
            begin
                state_next = last_chunk ? M_IDLE : M_QUOT;
            end
            default:
            begin
                state_next = M_IDLE;
            end
        endcase
    end

    // Shared multiplier operands and datapath registers.
    always_comb
    begin
        mul_a      = quot_reg;
        mul_b      = MUL_W'(BUCKETS);
        rem_next   = rem_reg;
        x_next     = x_reg;
        quot_next  = quot_reg;
        diff_next  = diff_reg;
        chunk_next = chunk_reg;
        done_next  = 1'b0;
        case (state_reg)
            M_IDLE:
            begin
                if (start)
                begin
                    rem_next   = '0;
                    chunk_next = '0;
                end
            end
            M_QUOT:
            begin
                mul_a     = fold;
                mul_b     = RECIP;
                x_next    = fold;
                quot_next = product[2*MUL_W-1:MUL_W];
            end
            M_BACK:
            begin
                diff_next = x_reg - product[MUL_W-1:0];
            end
            M_FIX:
            begin
                if (diff_reg >= MUL_W'(BUCKETS))
                begin
                    rem_next = BKT_W'(diff_reg - MUL_W'(BUCKETS));
                end
                else
                begin
                    rem_next = diff_reg[BKT_W-1:0];
                end
                chunk_next = chunk_reg + 1'b1;
                done_next  = last_chunk;
            end
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= M_IDLE;
            chunk_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            chunk_reg <= chunk_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        x_reg    <= x_next;
        quot_reg <= quot_next;
        diff_reg <= diff_next;
    end

    assign done   = done_reg;
    assign bucket = rem_reg;

endmodule

### rtl/hme_bucket_ram.sv
// Bucket memory: one row per bucket, each way holding a valid bit and a key.
module hme_bucket_ram #(
    parameter int BUCKETS = hme_pkg::BUCKETS_DEF,
    parameter int WAYS    = hme_pkg::WAYS_DEF
) (
    input  logic                               clk,
    input  hme_pkg::ram_ctl_t                  ctl,
    input  logic [$clog2(BUCKETS)-1:0]         addr,
    input  logic [WAYS-1:0][hme_pkg::KEY_W:0]  wdata,
    output logic [WAYS-1:0][hme_pkg::KEY_W:0]  rdata
);
    import hme_pkg::*;

    logic [WAYS-1:0][KEY_W:0] mem [BUCKETS];
    logic [WAYS-1:0][KEY_W:0] rd_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            if (ctl.we)
            begin
                mem[addr] <= wdata;
            end
            rd_reg <= mem[addr];
        end
    end

    assign rdata = rd_reg;

endmodule

### rtl/hash_multiset_engine.sv
// Top level of the hash multiset engine: sequencer, way compare and response register.
//
//  Channel | Role   | Payload                          | Handshake
//  --------+--------+----------------------------------+------------
//  req     | sink   | cmd[1:0], key[63:0] signed       | valid/ready
//  rsp     | source | found, status[1:0]               | valid/ready
//
// Insert, find and delete reduce the key modulo BUCKETS chunk by chunk, where CHUNKS is the
// count of (32 - log2 BUCKETS)-bit key chunks, three by default. For each chunk the modulo
// unit steps through quotient, back-multiply and correction; the first two use its shared multiplier.
// Clear runs a sweep that rewrites one bucket row per cycle.
// After reset the same sweep runs over every bucket row with req.ready low.
// A finished response waits in an output register, so a stalled rsp side does
// not hold back the next request.
module hash_multiset_engine #(
    parameter int BUCKETS = hme_pkg::BUCKETS_DEF,
    parameter int WAYS    = hme_pkg::WAYS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    hme_req_if.sink   req,
    hme_rsp_if.source rsp
);
    import hme_pkg::*;

    localparam int BKT_W = $clog2(BUCKETS);
    localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;

    state_t                   state_reg, state_next;
    logic [BKT_W-1:0]         row_cnt_reg, row_cnt_next;
    cmd_t                     cmd_reg, cmd_next;
    logic [KEY_W-1:0]         key_reg, key_next;
    logic                     res_found_reg, res_found_next;
    status_t                  res_status_reg, res_status_next;
    logic                     out_valid_reg, out_valid_next;
    logic                     out_found_reg, out_found_next;
    status_t                  out_status_reg, out_status_next;

    logic                     accept;
    logic                     last_row;
    logic                     load_out;
    logic                     mod_start;
    logic                     mod_done;
    logic [BKT_W-1:0]         bucket;

    ram_ctl_t                 ram_ctl;
    logic [BKT_W-1:0]         ram_addr;
    logic [WAYS-1:0][KEY_W:0] ram_wdata;
    logic [WAYS-1:0][KEY_W:0] row;
    logic [WAYS-1:0][KEY_W:0] wr_row;

    logic                     hit;
    logic [WAY_W-1:0]         hit_idx;
    logic                     free;
    logic [WAY_W-1:0]         free_idx;
    logic                     wr_en;

    hme_mod_unit #(
        .BUCKETS (BUCKETS)
    ) u_mod (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (mod_start),
        .key    (key_reg),
        .done   (mod_done),
        .bucket (bucket)
    );

    hme_bucket_ram #(
        .BUCKETS (BUCKETS),
        .WAYS    (WAYS)
    ) u_ram (
        .clk   (clk),
        .ctl   (ram_ctl),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (row)
    );

    assign accept   = (state_reg == S_IDLE) && req.valid;
    assign last_row = (row_cnt_reg == BKT_W'(BUCKETS - 1));

    // All ways of the bucket are compared at once; the lowest matching way and
    // the lowest free way win.
    always_comb
    begin
        hit      = 1'b0;
        hit_idx  = '0;
        free     = 1'b0;
        free_idx = '0;
        for (int w = WAYS - 1; w >= 0; w--)
        begin
            if (row[w][KEY_W] && (row[w][KEY_W-1:0] == key_reg))
            begin
                hit     = 1'b1;
                hit_idx = WAY_W'(w);
            end
            if (!row[w][KEY_W])
            begin
                free     = 1'b1;
                free_idx = WAY_W'(w);
            end
        end
    end

    always_comb
    begin
        wr_row = row;
        wr_en  = 1'b0;
        if ((cmd_reg == CMD_INSERT) && free)
        begin
            wr_row[free_idx] = {1'b1, key_reg};
            wr_en            = 1'b1;
        end
        else if ((cmd_reg == CMD_DELETE) && hit)
        begin
            wr_row[hit_idx][KEY_W] = 1'b0;
            wr_en                  = 1'b1;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_INIT:
            begin
                if (last_row)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = (cmd_t'(req.cmd) == CMD_CLEAR) ? S_SWEEP : S_REDUCE;
                end
            end
            S_REDUCE:
            begin
                if (mod_done)
                begin
                    state_next = S_UPDATE;
                end
            end
            S_UPDATE:
            begin
                state_next = S_REPLY;
            end
            S_SWEEP:
            begin
                if (last_row)
                begin
                    state_next = S_REPLY;
                end
            end
            S_REPLY:
            begin
                if (load_out)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Outputs of the sequencer.
    always_comb
    begin
        req.ready = 1'b0;
        mod_start = 1'b0;
        load_out  = 1'b0;
        ram_ctl   = '0;
        ram_addr  = bucket;
        ram_wdata = wr_row;
        case (state_reg)
            S_INIT, S_SWEEP:
            begin
                ram_ctl.en = 1'b1;
                ram_ctl.we = 1'b1;
                ram_addr   = row_cnt_reg;
                ram_wdata  = '0;
            end
            S_IDLE:
            begin
                req.ready = 1'b1;
                mod_start = req.valid && (cmd_t'(req.cmd) != CMD_CLEAR);
            end
            S_REDUCE:
            begin
                ram_ctl.en = mod_done;
            end
            S_UPDATE:
            begin
                ram_ctl.en = wr_en;
                ram_ctl.we = wr_en;
            end
            S_REPLY:
            begin
                load_out = !out_valid_reg || rsp.ready;
            end
            default:
            begin
                req.ready = 1'b0;
            end
        endcase
    end

    // Datapath and response register.
    always_comb
    begin
        row_cnt_next    = row_cnt_reg;
        cmd_next        = cmd_reg;
        key_next        = key_reg;
        res_found_next  = res_found_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_found_next  = out_found_reg;
        out_status_next = out_status_reg;

        if ((state_reg == S_INIT) || (state_reg == S_SWEEP))
        begin
            row_cnt_next = last_row ? '0 : row_cnt_reg + 1'b1;
        end

        if (accept)
        begin
            cmd_next        = cmd_t'(req.cmd);
            key_next        = req.key;
            res_found_next  = 1'b0;
            res_status_next = ST_OK;
        end

        if (state_reg == S_UPDATE)
        begin
            case (cmd_reg)
                CMD_INSERT:
                begin
                    res_found_next  = 1'b0;
                    res_status_next = free ? ST_OK : ST_FULL;
                end
                CMD_FIND:
                begin
                    res_found_next  = hit;
                    res_status_next = ST_OK;
                end
                CMD_DELETE:
                begin
                    res_found_next  = hit;
                    res_status_next = hit ? ST_OK : ST_ABSENT;
                end
                default:
                begin
                    res_found_next  = 1'b0;
                    res_status_next = ST_OK;
                end
            endcase
        end

        if (load_out)
        begin
            out_valid_next  = 1'b1;
            out_found_next  = res_found_reg;
            out_status_next = res_status_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            row_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            row_cnt_reg   <= row_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        key_reg        <= key_next;
        res_found_reg  <= res_found_next;
        res_status_reg <= res_status_next;
        out_found_reg  <= out_found_next;
        out_status_reg <= out_status_next;
    end

    assign rsp.valid  = out_valid_reg;
    assign rsp.found  = out_found_reg;
    assign rsp.status = out_status_reg;

endmodule

### rtl/hme_checker.sv
// Port-level checker for the hash multiset engine and its bind to the top level.
module hme_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         req_valid,
    input logic                         req_ready,
    input logic                         rsp_valid,
    input logic                         rsp_ready,
    input logic                         rsp_found,
    input logic [hme_pkg::STATUS_W-1:0] rsp_status
);
    import hme_pkg::*;

    logic [1:0] pend_reg, pend_next;
    logic       req_acc;
    logic       rsp_acc;

    assign req_acc = req_valid && req_ready;
    assign rsp_acc = rsp_valid && rsp_ready;

    // Requests taken whose response has not been delivered yet.
    always_comb
    begin
        pend_next = pend_reg;
        if (req_acc && !rsp_acc)
        begin
            pend_next = pend_reg + 1'b1;
        end
        else if (!req_acc && rsp_acc && (pend_reg != 2'd0))
        begin
            pend_next = pend_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("response dropped while stalled");

    a_rsp_stable: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> $stable(rsp_found) && $stable(rsp_status))
        else $error("response payload changed while stalled");

    a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        req_acc |=> !req_ready)
        else $error("engine ready again right after taking a request");

    a_no_orphan_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> pend_reg != 2'd0)
        else $error("response without an outstanding request");

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        req_acc |-> (pend_reg == 2'd0) || ((pend_reg == 2'd1) && rsp_valid))
        else $error("request taken while another is still being worked on");

endmodule

bind hash_multiset_engine hme_checker u_hme_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (req.valid),
    .req_ready  (req.ready),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .rsp_found  (rsp.found),
    .rsp_status (rsp.status)
);

### dv/testbench.sv
// Self-checking testbench for the hash multiset engine: directed table, then random traffic.
module testbench;
    import hme_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_BUCKETS  = BUCKETS_DEF;
    localparam int NUM_WAYS     = WAYS_DEF;
    localparam int NUM_SLOTS    = NUM_BUCKETS * NUM_WAYS;
    localparam int RANDOM_ITEMS = 1430;
    localparam int HOT_KEYS     = 16;
    localparam int HOT_BUCKETS  = 5;
    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 40;

    typedef struct packed {
        logic    found;
        status_t status;
    } reply_t;

    typedef struct {
        cmd_t        cmd;
        logic [63:0] key;
        bit          literal;
        logic        found;
        status_t     status;
    } dir_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    hme_req_if req_ch ();
    hme_rsp_if rsp_ch ();

    hash_multiset_engine #(
        .BUCKETS (NUM_BUCKETS),
        .WAYS    (NUM_WAYS)
    ) u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    always #5 clk = ~clk;

    // Shadow copy of the table contents.
    logic [63:0] table_keys [NUM_SLOTS];
    bit          table_used [NUM_SLOTS];

    reply_t      reply_queue[$];
    int          failures = 0;
    int          idle_cycles = 0;
    bit          req_idle_on = 1'b1;
    bit          rsp_idle_on = 1'b1;
    int          n_full = 0;
    int          n_hits = 0;
    int          n_absent = 0;
    int          n_clears = 0;
    int          n_replies = 0;
    logic [63:0] hot_keys [HOT_KEYS];

    // Rows with literal set carry a result that is obvious from the table state.
    dir_row_t directed_rows [23] = '{
        '{CMD_FIND,   64'h0000_0000_0000_0000, 1'b1, 1'b0, ST_OK},
        '{CMD_DELETE, 64'h0000_0000_0000_0000, 1'b1, 1'b0, ST_ABSENT},
        '{CMD_INSERT, 64'h7FFF_FFFF_FFFF_FFFF, 1'b1, 1'b0, ST_OK},
        '{CMD_INSERT, 64'h8000_0000_0000_0000, 1'b1, 1'b0, ST_OK},
        '{CMD_FIND,   64'h8000_0000_0000_0000, 1'b1, 1'b1, ST_OK},
        '{CMD_FIND,   64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b0, ST_OK},
        '{CMD_INSERT, 64'h0000_0000_0000_0005, 1'b1, 1'b0, ST_OK},
        '{CMD_INSERT, 64'h0000_0000_0000_0005, 1'b1, 1'b0, ST_OK},
        '{CMD_INSERT, 64'h0000_0000_0000_0005, 1'b1, 1'b0, ST_OK},
        '{CMD_INSERT, 64'h0000_0000_0000_0005, 1'b1, 1'b0, ST_OK},
        '{CMD_INSERT, 64'h0000_0000_0000_0405, 1'b1, 1'b0, ST_FULL},
        '{CMD_FIND,   64'h0000_0000_0000_0405, 1'b1, 1'b0, ST_OK},
        '{CMD_DELETE, 64'h0000_0000_0000_0005, 1'b0, 1'b0, ST_OK},
        '{CMD_INSERT, 64'h0000_0000_0000_0405, 1'b0, 1'b0, ST_OK},
        '{CMD_FIND,   64'h0000_0000_0000_0405, 1'b0, 1'b0, ST_OK},
        '{CMD_DELETE, 64'h0000_0000_0000_0005, 1'b0, 1'b0, ST_OK},
        '{CMD_DELETE, 64'h0000_0000_0000_0005, 1'b0, 1'b0, ST_OK},
        '{CMD_DELETE, 64'h0000_0000_0000_0005, 1'b0, 1'b0, ST_OK},
        '{CMD_DELETE, 64'h0000_0000_0000_0005, 1'b1, 1'b0, ST_ABSENT},
        '{CMD_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0, ST_OK},
        '{CMD_CLEAR,  64'hA5A5_5A5A_C3C3_3C3C, 1'b1, 1'b0, ST_OK},
        '{CMD_FIND,   64'h7FFF_FFFF_FFFF_FFFF, 1'b1, 1'b0, ST_OK},
        '{CMD_DELETE, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b0, ST_ABSENT}
    };

    function automatic reply_t apply_command(input cmd_t cmd, input logic [63:0] key);
        reply_t res;
        int     base;
        int     way;
        res.found  = 1'b0;
        res.status = ST_OK;
        base = int'(key % 64'(NUM_BUCKETS)) * NUM_WAYS;
        way = NUM_WAYS;
        case (cmd)
            CMD_INSERT:
            begin
                for (int w = NUM_WAYS - 1; w >= 0; w--)
                    if (!table_used[base + w])
                        way = w;
                if (way < NUM_WAYS)
                begin
                    table_keys[base + way] = key;
                    table_used[base + way] = 1'b1;
                end
                else
                begin
                    res.status = ST_FULL;
                    n_full++;
                end
            end
            CMD_FIND, CMD_DELETE:
            begin
                for (int w = NUM_WAYS - 1; w >= 0; w--)
                    if (table_used[base + w] && table_keys[base + w] == key)
                        way = w;
                if (way < NUM_WAYS)
                begin
                    res.found = 1'b1;
                    n_hits++;
                    if (cmd == CMD_DELETE)
                        table_used[base + way] = 1'b0;
                end
                else if (cmd == CMD_DELETE)
                begin
                    res.status = ST_ABSENT;
                    n_absent++;
                end
            end
            default:
            begin
                foreach (table_used[i])
                    table_used[i] = 1'b0;
                n_clears++;
            end
        endcase
        return res;
    endfunction

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_request(input cmd_t cmd, input logic [63:0] key, input bit literal,
                                input reply_t literal_reply);
        int     gap;
        reply_t res;
        gap = req_idle_on ? $urandom_range(0, 4) : 0;
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.cmd   <= cmd;
        req_ch.key   <= key;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        res = apply_command(cmd, key);
        reply_queue.push_back(literal ? literal_reply : res);
        @(negedge clk);
    endtask

    function automatic logic [63:0] random_key();
        return {$urandom, $urandom};
    endfunction

    // A small pool of keys crowded into a few buckets, so that buckets fill,
    // duplicates pile up and deletes mostly hit.
    task automatic refresh_hot_keys();
        logic [9:0] buckets [HOT_BUCKETS];
        logic [63:0] k;
        foreach (buckets[i])
            buckets[i] = 10'($urandom_range(0, NUM_BUCKETS - 1));
        foreach (hot_keys[i])
        begin
            k = random_key();
            k[9:0] = buckets[$urandom_range(0, HOT_BUCKETS - 1)];
            hot_keys[i] = k;
        end
    endtask

    // Response side: a fresh stall draw for every response.
    initial
    begin
        rsp_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            int stall;
            @(negedge clk);
            stall = rsp_idle_on ? $urandom_range(0, 4) : 0;
            if (stall > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            rsp_ch.ready <= 1'b1;
            @(posedge clk);
            while (!rsp_ch.valid)
                @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        reply_t want;
        if (rst_n)
        begin
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("watchdog: no request or response moved for %0d cycles", idle_cycles);
                $display("hash_multiset_engine regression: fail");
                $finish;
            end
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                n_replies++;
                if (reply_queue.size() == 0)
                begin
                    $error("response with no request outstanding");
                    failures++;
                end
                else
                begin
                    want = reply_queue.pop_front();
                    if (rsp_ch.found !== want.found)
                    begin
                        $error("found: expected %0d, actual %0d", want.found, rsp_ch.found);
                        failures++;
                    end
                    if (rsp_ch.status !== want.status)
                    begin
                        $error("status: expected %0d, actual %0d", want.status, rsp_ch.status);
                        failures++;
                    end
                end
            end
        end
    end

    initial
    begin
        int          pick;
        cmd_t        cmd;
        logic [63:0] key;
        reply_t      lit;
        foreach (table_used[i])
            table_used[i] = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.cmd   = CMD_INSERT;
        req_ch.key   = '0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_rows[i])
        begin
            lit.found  = directed_rows[i].found;
            lit.status = directed_rows[i].status;
            send_request(directed_rows[i].cmd, directed_rows[i].key,
                         directed_rows[i].literal, lit);
        end

        lit = '0;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n % 150 == 0)
            begin
                refresh_hot_keys();
                req_idle_on = ($urandom_range(0, 3) != 0);
                rsp_idle_on = ($urandom_range(0, 3) != 0);
            end
            pick = $urandom_range(0, 99);
            if (pick < 1)
            begin
                cmd = CMD_CLEAR;
                key = random_key();
            end
            else if (pick < 11)
            begin
                cmd = cmd_t'($urandom_range(0, 2));
                key = random_key();
            end
            else
            begin
                key = hot_keys[$urandom_range(0, HOT_KEYS - 1)];
                // Near miss: same bucket, one upper bit different.
                if ($urandom_range(0, 9) == 0)
                    key ^= 64'd1 << $urandom_range(10, 63);
                pick = $urandom_range(0, 99);
                cmd = (pick < 45) ? CMD_INSERT : (pick < 72) ? CMD_FIND : CMD_DELETE;
            end
            send_request(cmd, key, 1'b0, lit);
        end
        req_ch.valid <= 1'b0;

        while (reply_queue.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d requests: %0d hits, %0d full inserts, %0d absent deletes, %0d clears",
                 23 + RANDOM_ITEMS, n_hits, n_full, n_absent, n_clears);
        $display("%0d responses checked, %0d mismatches", n_replies, failures);
        if (failures == 0)
            $display("hash_multiset_engine regression: pass");
        else
            $display("hash_multiset_engine regression: fail");
        $finish;
    end

endmodule

### sim.f
rtl/hme_pkg.sv
rtl/hme_if.sv
rtl/hme_mod_unit.sv
rtl/hme_bucket_ram.sv
rtl/hash_multiset_engine.sv
rtl/hme_checker.sv
dv/testbench.sv
